// ===== sv/sorted_interval_gap_clustering_top_defines.svh =====
// ----------------------------------------------------------------------------
// sorted_interval_gap_clustering_top_defines
// assertion macros shared by the gap clustering modules
// ----------------------------------------------------------------------------
`ifndef SORTED_INTERVAL_GAP_CLUSTERING_TOP_DEFINES_SVH
`define SORTED_INTERVAL_GAP_CLUSTERING_TOP_DEFINES_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define SIGC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, off during reset
`define SIGC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/sigc_pkg.sv =====
// ----------------------------------------------------------------------------
// sigc_pkg
// widths, defaults and shared types of the gap clustering block
// ----------------------------------------------------------------------------
package sigc_pkg;

    localparam int CHROM_W = 7;
    localparam int COORD_W = 31;
    localparam int LEN_W   = 32;
    localparam int RC_W    = 18;
    localparam int NUM_W   = 17;

    localparam int NUM_CHROMS_DEF  = 128;
    localparam int MAX_REGIONS_DEF = 131072;

    localparam logic [COORD_W-1:0] MIN_GAP_RESET = COORD_W'(500);

    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 192;

    // event queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;
    localparam int QC_W    = 3;

    // push counts from the front
    localparam logic [1:0] PUSH_NONE = 2'd0;
    localparam logic [1:0] PUSH_ONE  = 2'd1;
    localparam logic [1:0] PUSH_TWO  = 2'd2;

    // one closed cluster on its way to the back
    typedef struct packed {
        logic [CHROM_W-1:0] chrom;
        logic [COORD_W-1:0] start;
        logic [COORD_W-1:0] stop;
        logic [RC_W-1:0]    count;
        logic               is_last;
    } t_event;

    typedef struct packed {
        logic [1:0] n;
        t_event     ev0;
        t_event     ev1;
    } t_push;

endpackage

// ===== sv/sigc_ram.sv =====
// ----------------------------------------------------------------------------
// sigc_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module sigc_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 128,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // read returns the old contents on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== sv/sigc_front.sv =====
// ----------------------------------------------------------------------------
// sigc_front
// holds the open cluster, decides splits and emits closed clusters
// ----------------------------------------------------------------------------
module sigc_front
    import sigc_pkg::*;
#(
    parameter int MAX_REGIONS = MAX_REGIONS_DEF,
    localparam int CNT_W      = $clog2(MAX_REGIONS + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    input  logic [COORD_W-1:0] i_cfg_data,
    input  logic               i_accept,
    input  logic [CHROM_W-1:0] i_chrom,
    input  logic [COORD_W-1:0] i_start,
    input  logic [COORD_W-1:0] i_stop,
    input  logic               i_final,
    output t_push              o_push
);

    logic               r_min_gap;
    logic [COORD_W-1:0] r_gap;
    logic               r_open;
    logic [CHROM_W-1:0] r_chrom;
    logic [COORD_W-1:0] r_start;
    logic [COORD_W-1:0] r_max_end;
    logic [CNT_W-1:0]   r_cnt;

    logic               split;
    logic               merge;
    logic [COORD_W-1:0] gap;
    logic [CHROM_W-1:0] n_chrom;
    logic [COORD_W-1:0] n_start;
    logic [COORD_W-1:0] n_max_end;
    logic [CNT_W-1:0]   n_cnt;
    logic [CNT_W+RC_W-1:0] old_cnt_ext;
    logic [CNT_W+RC_W-1:0] new_cnt_ext;
    t_event             ev_old;
    t_event             ev_fin;

    assign gap   = i_start - r_max_end;
    assign split = r_open && ((i_chrom != r_chrom) ||
                   ((i_start > r_max_end) && (gap > r_gap)));
    assign merge = r_open && !split;

    always_comb begin
        if (merge) begin
            n_chrom   = r_chrom;
            n_start   = r_start;
            n_max_end = (i_stop > r_max_end) ? i_stop : r_max_end;
            n_cnt     = (r_cnt < CNT_W'(MAX_REGIONS)) ? r_cnt + CNT_W'(1) : r_cnt;
        end else begin
            n_chrom   = i_chrom;
            n_start   = i_start;
            n_max_end = i_stop;
            n_cnt     = CNT_W'(1);
        end
    end

    assign old_cnt_ext = {{RC_W{1'b0}}, r_cnt};
    assign new_cnt_ext = {{RC_W{1'b0}}, n_cnt};

    always_comb begin
        ev_old.chrom   = r_chrom;
        ev_old.start   = r_start;
        ev_old.stop    = r_max_end;
        ev_old.count   = old_cnt_ext[RC_W-1:0];
        ev_old.is_last = 1'b0;
        ev_fin.chrom   = n_chrom;
        ev_fin.start   = n_start;
        ev_fin.stop    = n_max_end;
        ev_fin.count   = new_cnt_ext[RC_W-1:0];
        ev_fin.is_last = 1'b1;
    end

    always_comb begin
        o_push.n   = PUSH_NONE;
        o_push.ev0 = ev_old;
        o_push.ev1 = ev_fin;
        if (i_accept) begin
            priority if (split && i_final) begin
                o_push.n = PUSH_TWO;
            end else if (split) begin
                o_push.n = PUSH_ONE;
            end else if (i_final) begin
                o_push.n   = PUSH_ONE;
                o_push.ev0 = ev_fin;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_gap <= 1'b0;
            r_gap     <= MIN_GAP_RESET;
            r_open    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_gap     <= i_cfg_data;
                r_min_gap <= 1'b1;
            end
            if (i_accept) begin
                r_open <= !i_final;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_chrom   <= n_chrom;
            r_start   <= n_start;
            r_max_end <= n_max_end;
            r_cnt     <= n_cnt;
        end
    end

    `include "sorted_interval_gap_clustering_top_defines.svh"

    `SIGC_ASSERT_NOW(a_fe_split_needs_open, split, r_open, "split without open cluster")
    `SIGC_ASSERT_NXT(a_fe_final_closes, i_accept && i_final, !r_open, "final left cluster open")
    `SIGC_ASSERT_NXT(a_fe_cfg_taken, i_cfg_valid, r_min_gap, "config write not taken")

endmodule

// ===== sv/sigc_queue.sv =====
// ----------------------------------------------------------------------------
// sigc_queue
// short event queue, up to two pushes and one pop per cycle
// ----------------------------------------------------------------------------
module sigc_queue
    import sigc_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_push  i_push,
    input  logic   i_pop,
    output t_event o_head,
    output logic   o_head_valid,
    output logic   o_room
);

    t_event          r_q [Q_DEPTH];
    logic [Q_AW-1:0] r_wp;
    logic [Q_AW-1:0] r_rp;
    logic [QC_W-1:0] r_cnt;
    logic            pop;

    assign o_head       = r_q[r_rp];
    assign o_head_valid = (r_cnt != QC_W'(0));
    assign pop          = i_pop && o_head_valid;
    // room for the worst case of two events
    assign o_room       = (r_cnt <= QC_W'(Q_DEPTH - 2));

    always_ff @(posedge i_clk) begin
        if (i_push.n != PUSH_NONE) begin
            r_q[r_wp] <= i_push.ev0;
        end
        if (i_push.n == PUSH_TWO) begin
            r_q[r_wp + Q_AW'(1)] <= i_push.ev1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + Q_AW'(i_push.n);
            r_rp  <= r_rp + Q_AW'(pop);
            r_cnt <= r_cnt + QC_W'(i_push.n) - QC_W'(pop);
        end
    end

    `include "sorted_interval_gap_clustering_top_defines.svh"

    `SIGC_ASSERT_NOW(a_q_no_overflow, i_push.n != PUSH_NONE, (r_cnt + QC_W'(i_push.n)) <= QC_W'(Q_DEPTH), "queue overflow")
    `SIGC_ASSERT_NOW(a_q_push_legal, 1'b1, i_push.n != 2'd3, "bad push count")

endmodule

// ===== sv/sigc_back.sv =====
// ----------------------------------------------------------------------------
// sigc_back
// per-chromosome counts, ordinals, longest length and the output register
// ----------------------------------------------------------------------------
module sigc_back
    import sigc_pkg::*;
#(
    parameter int NUM_CHROMS  = NUM_CHROMS_DEF,
    parameter int MAX_REGIONS = MAX_REGIONS_DEF,
    localparam int CNT_W      = $clog2(MAX_REGIONS + 1),
    localparam int TBL_DEPTH  = (NUM_CHROMS < (1 << CHROM_W)) ? NUM_CHROMS : (1 << CHROM_W),
    localparam int AW         = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_event               i_head,
    input  logic                 i_head_valid,
    output logic                 o_pop,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [M_TDATA_W-1:0] o_m_tdata,
    output logic                 o_m_tuser,
    output logic                 o_m_tlast
);

    // stage b: event plus table read data
    logic                 r_b_valid;
    t_event               r_b_ev;
    logic [TBL_DEPTH-1:0] r_tv;
    logic                 r_fw_valid;
    logic [AW-1:0]        r_fw_addr;
    logic [CNT_W-1:0]     r_fw_cnt;
    logic [NUM_W-1:0]     r_num;
    logic [LEN_W-1:0]     r_best;

    logic                 r_o_valid;
    logic [M_TDATA_W-1:0] r_o_data;
    logic                 r_o_user;
    logic                 r_o_last;

    logic                  out_ready;
    logic                  b_adv;
    logic                  b_ready;
    logic [CHROM_W+AW-1:0] head_ext;
    logic [CHROM_W+AW-1:0] b_ext;
    logic [AW-1:0]         head_addr;
    logic [AW-1:0]         b_addr;
    logic [CNT_W-1:0]      rd_data;
    logic                  in_tbl;
    logic [CNT_W-1:0]      old_cnt;
    logic [CNT_W-1:0]      new_cnt;
    logic [CNT_W-1:0]      ccount;
    logic [CNT_W+RC_W-1:0] ccount_ext;
    logic [LEN_W-1:0]      b_len;
    logic                  longer;
    logic [LEN_W-1:0]      n_best;
    logic [M_TDATA_W-1:0]  n_o_data;

    assign out_ready = !r_o_valid || i_m_tready;
    assign b_adv     = r_b_valid && out_ready;
    assign b_ready   = !r_b_valid || out_ready;
    assign o_pop     = i_head_valid && b_ready;

    assign head_ext  = {{AW{1'b0}}, i_head.chrom};
    assign b_ext     = {{AW{1'b0}}, r_b_ev.chrom};
    assign head_addr = head_ext[AW-1:0];
    assign b_addr    = b_ext[AW-1:0];
    assign in_tbl    = (32'(r_b_ev.chrom) < TBL_DEPTH);

    sigc_ram #(
        .WIDTH (CNT_W),
        .DEPTH (TBL_DEPTH)
    ) u_cnt_ram (
        .i_clk     (i_clk),
        .i_wr_en   (b_adv && in_tbl && !r_b_ev.is_last),
        .i_wr_addr (b_addr),
        .i_wr_data (new_cnt),
        .i_rd_en   (o_pop),
        .i_rd_addr (head_addr),
        .o_rd_data (rd_data)
    );

    // the previous write lands in the same cycle as this read was issued
    always_comb begin
        if (r_fw_valid && (r_fw_addr == b_addr)) begin
            old_cnt = r_fw_cnt;
        end else if (in_tbl && r_tv[b_addr]) begin
            old_cnt = rd_data;
        end else begin
            old_cnt = '0;
        end
    end

    assign new_cnt    = (old_cnt < CNT_W'(MAX_REGIONS)) ? old_cnt + CNT_W'(1) : old_cnt;
    assign ccount     = in_tbl ? new_cnt : CNT_W'(1);
    assign ccount_ext = {{RC_W{1'b0}}, ccount};

    assign b_len  = (r_b_ev.stop >= r_b_ev.start) ?
                    (LEN_W'(r_b_ev.stop) - LEN_W'(r_b_ev.start) + LEN_W'(1)) : '0;
    assign longer = (b_len > r_best);
    assign n_best = longer ? b_len : r_best;

    assign n_o_data = M_TDATA_W'({n_best,
                                  ccount_ext[RC_W-1:0],
                                  r_num,
                                  r_b_ev.count,
                                  b_len,
                                  r_b_ev.stop,
                                  r_b_ev.start,
                                  r_b_ev.chrom});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid  <= 1'b0;
            r_o_valid  <= 1'b0;
            r_tv       <= '0;
            r_fw_valid <= 1'b0;
            r_num      <= '0;
            r_best     <= '0;
        end else begin
            if (b_ready) begin
                r_b_valid <= o_pop;
            end
            if (out_ready) begin
                r_o_valid <= r_b_valid;
            end
            if (b_adv) begin
                if (r_b_ev.is_last) begin
                    // end of stream: all stream state back to its reset value
                    r_tv       <= '0;
                    r_fw_valid <= 1'b0;
                    r_num      <= '0;
                    r_best     <= '0;
                end else begin
                    if (in_tbl) begin
                        r_tv[b_addr] <= 1'b1;
                        r_fw_valid   <= 1'b1;
                    end
                    r_num  <= r_num + NUM_W'(1);
                    r_best <= n_best;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_b_ev <= i_head;
        end
        if (b_adv && in_tbl) begin
            r_fw_addr <= b_addr;
            r_fw_cnt  <= new_cnt;
        end
        if (b_adv) begin
            r_o_data <= n_o_data;
            r_o_user <= longer;
            r_o_last <= r_b_ev.is_last;
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = r_o_data;
    assign o_m_tuser  = r_o_user;
    assign o_m_tlast  = r_o_last;

    `include "sorted_interval_gap_clustering_top_defines.svh"

    `SIGC_ASSERT_NXT(a_bk_last_resets_num, b_adv && r_b_ev.is_last, r_num == '0, "ordinal not cleared")
    `SIGC_ASSERT_NOW(a_bk_new_longest, r_o_valid && r_o_user, r_o_data[LEN_W+RC_W+NUM_W+RC_W+LEN_W+2*COORD_W+CHROM_W-1 -: LEN_W] == r_o_data[LEN_W+2*COORD_W+CHROM_W-1 -: LEN_W], "new longest mismatch")
    `SIGC_ASSERT_NXT(a_bk_hold_on_stall, r_o_valid && !i_m_tready, r_o_valid && $stable(r_o_data), "result lost on stall")

endmodule

// ===== sv/sorted_interval_gap_clustering_top.sv =====
// ----------------------------------------------------------------------------
// sorted_interval_gap_clustering_top
// merges a sorted stream of genomic regions into gap-limited clusters
// ----------------------------------------------------------------------------
// Regions enter on the s_axis channel: tdata holds chrom [6:0], region_start
// [37:7] and region_end [68:38]; tlast marks the final region of the stream.
// Each closed cluster leaves on the m_axis channel as one beat; tuser carries
// new_longest and tlast marks the final cluster of the stream.
// A region is taken every cycle while tready is high; a region that closes a
// cluster and also ends the stream yields two beats.
// A closed cluster passes through the queue, stage b and the output register.
// The front keeps the open cluster and pushes closed clusters into a
// four-entry queue; the back reads and updates the per-chromosome count
// table (one ram port each way, registered read) and fills the output
// register. tready drops while the queue has fewer than two free entries.
// A stalled receiver holds the output beat; the queue then fills and the
// input side stops, nothing is dropped.
// The cfg channel writes min_gap (reset 500) and is ready outside reset;
// write it only while the block is idle. Both ready lines are low in reset,
// which clears the count table at once through valid bits, as a stream end does.
// ----------------------------------------------------------------------------
module sorted_interval_gap_clustering_top
    import sigc_pkg::*;
#(
    parameter int NUM_CHROMS  = NUM_CHROMS_DEF,
    parameter int MAX_REGIONS = MAX_REGIONS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // chrom, region_start, region_end, zero fill
    input  logic [S_TDATA_W-1:0] i_s_axis_tdata,
    input  logic                 i_s_axis_tlast,
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // cluster_chrom, cluster_start, cluster_end, cluster_length, region_count,
    // cluster_number, chrom_cluster_count, longest_length, zero fill
    output logic [M_TDATA_W-1:0] o_m_axis_tdata,
    // new_longest
    output logic                 o_m_axis_tuser,
    output logic                 o_m_axis_tlast,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [COORD_W-1:0]   i_cfg_data
);

    t_push  push;
    t_event head;
    logic   head_valid;
    logic   pop;
    logic   room;
    logic   accept;
    logic [M_TDATA_W-1:0] m_tdata;

    assign o_cfg_ready     = i_rst_n;
    assign o_s_axis_tready = room && i_rst_n;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    sigc_front #(
        .MAX_REGIONS (MAX_REGIONS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_chrom     (i_s_axis_tdata[CHROM_W-1:0]),
        .i_start     (i_s_axis_tdata[CHROM_W+COORD_W-1:CHROM_W]),
        .i_stop      (i_s_axis_tdata[CHROM_W+2*COORD_W-1:CHROM_W+COORD_W]),
        .i_final     (i_s_axis_tlast),
        .o_push      (push)
    );

    sigc_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_pop        (pop),
        .o_head       (head),
        .o_head_valid (head_valid),
        .o_room       (room)
    );

    sigc_back #(
        .NUM_CHROMS  (NUM_CHROMS),
        .MAX_REGIONS (MAX_REGIONS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .i_head_valid (head_valid),
        .o_pop        (pop),
        .o_m_tvalid   (o_m_axis_tvalid),
        .i_m_tready   (i_m_axis_tready),
        .o_m_tdata    (m_tdata),
        .o_m_tuser    (o_m_axis_tuser),
        .o_m_tlast    (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = m_tdata;

endmodule

// ===== dv/tb_sorted_interval_gap_clustering_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_interval_gap_clustering_top
// self-checking bench for the gap-limited region clustering block
// ----------------------------------------------------------------------------
// Sorted region streams go in on the slave channel. A cycle-free model of the
// clustering rules predicts every closed cluster. Each output beat is compared
// field by field with the oldest predicted cluster. Directed cases cover the
// gap boundary, overlap, inverted regions, chromosome changes and the final
// region. Random sorted streams follow, with noise, random min_gap values and
// random stalls on both sides. The run ends with a back to back stream with
// no idling on either side.
// ----------------------------------------------------------------------------
module tb_sorted_interval_gap_clustering_top;
    import sigc_pkg::*;

    localparam logic [COORD_W-1:0] COORD_MAX = '1;

    // output tdata field offsets, lowest bit up
    localparam int OFF_START = CHROM_W;
    localparam int OFF_END   = OFF_START + COORD_W;
    localparam int OFF_LEN   = OFF_END + COORD_W;
    localparam int OFF_RC    = OFF_LEN + LEN_W;
    localparam int OFF_NUM   = OFF_RC + RC_W;
    localparam int OFF_CCNT  = OFF_NUM + NUM_W;
    localparam int OFF_LONG  = OFF_CCNT + RC_W;

    typedef struct packed {
        logic [CHROM_W-1:0] chrom;
        logic [COORD_W-1:0] start;
        logic [COORD_W-1:0] stop;
        logic               fin;
    } t_region;

    typedef struct packed {
        logic [CHROM_W-1:0] chrom;
        logic [COORD_W-1:0] start;
        logic [COORD_W-1:0] stop;
        logic [LEN_W-1:0]   length;
        logic [RC_W-1:0]    regions;
        logic [NUM_W-1:0]   ordinal;
        logic [RC_W-1:0]    chrom_count;
        logic [LEN_W-1:0]   longest;
        logic               new_longest;
        logic               is_last;
    } t_cluster;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 s_tlast = 1'b0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;
    logic                 m_tlast;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [COORD_W-1:0]   cfg_data = '0;

    always #5 i_clk = ~i_clk;

    sorted_interval_gap_clustering_top u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tlast  (m_tlast),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data)
    );

    // clustering state of the predictor
    logic [COORD_W-1:0] gap_limit = MIN_GAP_RESET;
    logic               clu_open = 1'b0;
    logic [CHROM_W-1:0] clu_chrom = '0;
    logic [COORD_W-1:0] clu_start = '0;
    logic [COORD_W-1:0] clu_max_end = '0;
    logic [RC_W-1:0]    clu_regions = '0;
    logic [NUM_W-1:0]   clu_ordinal = '0;
    logic [LEN_W-1:0]   longest_seen = '0;
    logic [RC_W-1:0]    chrom_closed [NUM_CHROMS_DEF];

    t_cluster pending_clusters[$];
    int       mismatch_count = 0;
    bit       tx_idle_on = 1'b0;
    bit       rx_idle_on = 1'b0;
    int       rx_stall_left = 0;

    function automatic void clear_clusters();
        clu_open     = 1'b0;
        clu_chrom    = '0;
        clu_start    = '0;
        clu_max_end  = '0;
        clu_regions  = '0;
        clu_ordinal  = '0;
        longest_seen = '0;
        foreach (chrom_closed[i]) chrom_closed[i] = '0;
    endfunction

    function automatic void close_cluster(bit is_last);
        t_cluster c;
        c.chrom  = clu_chrom;
        c.start  = clu_start;
        c.stop   = clu_max_end;
        c.length = (clu_max_end >= clu_start) ?
                   LEN_W'(clu_max_end) - LEN_W'(clu_start) + 1 : '0;
        if (chrom_closed[clu_chrom] < MAX_REGIONS_DEF)
            chrom_closed[clu_chrom]++;
        c.chrom_count = chrom_closed[clu_chrom];
        c.new_longest = c.length > longest_seen;
        if (c.new_longest)
            longest_seen = c.length;
        c.longest = longest_seen;
        c.regions = clu_regions;
        c.ordinal = clu_ordinal;
        c.is_last = is_last;
        clu_ordinal = clu_ordinal + 1'b1;
        clu_open = 1'b0;
        pending_clusters.push_back(c);
    endfunction

    function automatic void cluster_region(t_region r);
        if (clu_open && (r.chrom != clu_chrom ||
                         (r.start > clu_max_end && r.start - clu_max_end > gap_limit)))
            close_cluster(1'b0);
        if (clu_open) begin
            if (r.stop > clu_max_end)
                clu_max_end = r.stop;
            if (clu_regions < MAX_REGIONS_DEF)
                clu_regions++;
        end else begin
            clu_open    = 1'b1;
            clu_chrom   = r.chrom;
            clu_start   = r.start;
            clu_max_end = r.stop;
            clu_regions = RC_W'(1);
        end
        if (r.fin) begin
            close_cluster(1'b1);
            clear_clusters();
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [LEN_W-1:0] got,
                                   input logic [LEN_W-1:0] want);
        if (mismatch_count < 40)
            $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    // sends one region, optionally after a random gap, and predicts on acceptance
    task automatic send_region(input t_region r);
        if (tx_idle_on && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_tdata <= S_TDATA_W'({r.stop, r.start, r.chrom});
        s_tlast <= r.fin;
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
        cluster_region(r);
    endtask

    task automatic send_fields(input int chrom, input logic [COORD_W-1:0] start,
                               input logic [COORD_W-1:0] stop, input bit fin);
        t_region r;
        r.chrom = CHROM_W'(chrom);
        r.start = start;
        r.stop  = stop;
        r.fin   = fin;
        send_region(r);
    endtask

    task automatic wait_clusters_drained();
        s_valid <= 1'b0;
        while (pending_clusters.size() != 0) @(posedge i_clk);
        // regions that close nothing may still sit in the front
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_min_gap(input logic [COORD_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        cfg_valid <= 1'b0;
        gap_limit = value;
    endtask

    // receiver stalls in random bursts
    always @(posedge i_clk) begin
        if (rx_stall_left > 0) begin
            rx_stall_left <= rx_stall_left - 1;
            m_ready       <= 1'b0;
        end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
            rx_stall_left <= $urandom_range(0, 12);
            m_ready       <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_cluster want;
        if (i_rst_n && m_valid && m_ready) begin
            if (pending_clusters.size() == 0) begin
                report_mismatch("beat with no cluster pending", 1, 0);
            end else begin
                want = pending_clusters.pop_front();
                if (m_tdata[0 +: CHROM_W] !== want.chrom)
                    report_mismatch("cluster_chrom", LEN_W'(m_tdata[0 +: CHROM_W]),
                                    LEN_W'(want.chrom));
                if (m_tdata[OFF_START +: COORD_W] !== want.start)
                    report_mismatch("cluster_start", LEN_W'(m_tdata[OFF_START +: COORD_W]),
                                    LEN_W'(want.start));
                if (m_tdata[OFF_END +: COORD_W] !== want.stop)
                    report_mismatch("cluster_end", LEN_W'(m_tdata[OFF_END +: COORD_W]),
                                    LEN_W'(want.stop));
                if (m_tdata[OFF_LEN +: LEN_W] !== want.length)
                    report_mismatch("cluster_length", m_tdata[OFF_LEN +: LEN_W],
                                    want.length);
                if (m_tdata[OFF_RC +: RC_W] !== want.regions)
                    report_mismatch("region_count", LEN_W'(m_tdata[OFF_RC +: RC_W]),
                                    LEN_W'(want.regions));
                if (m_tdata[OFF_NUM +: NUM_W] !== want.ordinal)
                    report_mismatch("cluster_number", LEN_W'(m_tdata[OFF_NUM +: NUM_W]),
                                    LEN_W'(want.ordinal));
                if (m_tdata[OFF_CCNT +: RC_W] !== want.chrom_count)
                    report_mismatch("chrom_cluster_count", LEN_W'(m_tdata[OFF_CCNT +: RC_W]),
                                    LEN_W'(want.chrom_count));
                if (m_tdata[OFF_LONG +: LEN_W] !== want.longest)
                    report_mismatch("longest_length", m_tdata[OFF_LONG +: LEN_W],
                                    want.longest);
                if (m_tdata[M_TDATA_W-1:OFF_LONG+LEN_W] !== '0)
                    report_mismatch("tdata fill",
                                    LEN_W'(m_tdata[M_TDATA_W-1:OFF_LONG+LEN_W]), 0);
                if (m_tuser !== want.new_longest)
                    report_mismatch("new_longest", LEN_W'(m_tuser), LEN_W'(want.new_longest));
                if (m_tlast !== want.is_last)
                    report_mismatch("last_cluster", LEN_W'(m_tlast), LEN_W'(want.is_last));
            end
        end
    end

    // gap boundary, overlap, inverted region, chromosome change, final merge
    task automatic test_gap_rules();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        send_fields(0, 100, 200, 0);
        send_fields(0, 700, 800, 0);                 // gap equals min_gap, merges
        send_fields(0, 1301, 1400, 0);               // one past min_gap, splits
        send_fields(0, 1350, 1360, 0);               // starts inside running end
        send_fields(0, 5000, 10, 0);                 // end below start
        send_fields(0, 5100, 5200, 0);               // closes a zero length cluster
        send_fields(1, 0, COORD_MAX, 0);
        send_fields(1, 5, 6, 0);
        send_fields(127, COORD_MAX, COORD_MAX, 0);
        send_fields(127, COORD_MAX, 0, 1);           // final region merges
        wait_clusters_drained();
    endtask

    // zero and full min_gap, final region that also splits, lone final region
    task automatic test_gap_extremes();
        set_min_gap('0);
        send_fields(3, 10, 20, 0);
        send_fields(3, 21, 30, 0);
        wait_clusters_drained();                     // pause with a cluster open
        send_fields(3, 30, 30, 0);
        send_fields(3, 31, 40, 1);                   // splits and ends the stream
        wait_clusters_drained();
        set_min_gap(COORD_MAX);
        send_fields(5, 0, 0, 0);
        send_fields(5, COORD_MAX, COORD_MAX, 0);
        send_fields(6, 1, 1, 1);
        send_fields(0, 9, 9, 1);
        wait_clusters_drained();
        set_min_gap(MIN_GAP_RESET);
    endtask

    function automatic logic [COORD_W-1:0] clamp_coord(input longint value);
        if (value < 0)
            return '0;
        if (value > longint'(COORD_MAX))
            return COORD_MAX;
        return COORD_W'(value);
    endfunction

    // sorted streams with random content, a share of noise, random min_gap
    task automatic test_random_streams(input int n_regions);
        int      sent;
        int      stream_len;
        int      chrom;
        longint  next_start;
        longint  span;
        t_region r;
        sent = 0;
        while (sent < n_regions) begin
            if ($urandom_range(0, 2) == 0) begin
                wait_clusters_drained();
                case ($urandom_range(0, 4))
                    0: set_min_gap('0);
                    1: set_min_gap(MIN_GAP_RESET);
                    2: set_min_gap(COORD_W'($urandom_range(1, 2000)));
                    3: set_min_gap(COORD_W'($urandom()));
                    default: set_min_gap(COORD_MAX);
                endcase
            end
            tx_idle_on = $urandom_range(0, 3) != 0;
            rx_idle_on = $urandom_range(0, 3) != 0;
            stream_len = $urandom_range(1, 40);
            if (stream_len > n_regions - sent)
                stream_len = n_regions - sent;
            chrom = $urandom_range(0, 20);
            for (int k = 0; k < stream_len; k++) begin
                if ($urandom_range(0, 11) == 0) begin
                    r.chrom = CHROM_W'($urandom());
                    r.start = COORD_W'($urandom());
                    r.stop  = COORD_W'($urandom());
                    r.fin   = $urandom_range(0, 49) == 0;
                end else begin
                    if (k > 0 && $urandom_range(0, 5) == 0)
                        chrom = (chrom + $urandom_range(1, 30) > 127) ?
                                127 : chrom + $urandom_range(1, 30);
                    if (!clu_open || CHROM_W'(chrom) != clu_chrom) begin
                        next_start = $urandom_range(0, 1) ?
                                     longint'(COORD_W'($urandom())) : $urandom_range(0, 5000);
                    end else begin
                        case ($urandom_range(0, 4))
                            0: next_start = longint'(clu_max_end) - $urandom_range(0, 1000);
                            1: next_start = longint'(clu_max_end) +
                                            ($urandom() % (longint'(gap_limit) + 1));
                            2: next_start = longint'(clu_max_end) + gap_limit;
                            3: next_start = longint'(clu_max_end) + gap_limit + 1;
                            default: next_start = longint'(clu_max_end) + gap_limit +
                                                  $urandom_range(2, 100000);
                        endcase
                    end
                    r.chrom = CHROM_W'(chrom);
                    r.start = clamp_coord(next_start);
                    span = $urandom_range(0, 2000);
                    if ($urandom_range(0, 9) == 0)
                        r.stop = clamp_coord(longint'(r.start) - span);
                    else if ($urandom_range(0, 19) == 0)
                        r.stop = COORD_MAX;
                    else
                        r.stop = clamp_coord(longint'(r.start) + span);
                    r.fin = (k == stream_len - 1);
                end
                send_region(r);
                sent++;
            end
        end
        wait_clusters_drained();
    endtask

    // regions back to back with no idling on either side
    task automatic test_back_to_back();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        set_min_gap(MIN_GAP_RESET);
        for (int k = 0; k < 40; k++)
            send_fields(k / 8, COORD_W'(1000 * (k % 8)),
                        COORD_W'(1000 * (k % 8) + (k % 3) * 400), k == 39);
        wait_clusters_drained();
    endtask

    initial begin
        clear_clusters();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_gap_rules();
        test_gap_extremes();
        test_random_streams(740);
        test_back_to_back();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin
        #15_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== sorted_interval_gap_clustering_top.f =====
+incdir+sv
sv/sigc_pkg.sv
sv/sigc_ram.sv
sv/sigc_front.sv
sv/sigc_queue.sv
sv/sigc_back.sv
sv/sorted_interval_gap_clustering_top.sv
dv/tb_sorted_interval_gap_clustering_top.sv
